@@ sv/tcce_pkg.sv @@
// Package for the text console cell engine: character codes, field widths,
// register indexes, reset values and the sweep command struct.
// No dependencies; every other file of the block but tcce_ram uses it.
package tcce_pkg;

    // Default geometry of the cell store and tab spacing
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int TAB_STOP_DEF    = 4;

    // Field widths of the channels
    localparam int CHAR_W       = 8;
    localparam int READ_ROW_W   = 6;
    localparam int READ_COL_W   = 7;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 6;

    // Configuration port
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int COLS_CFG_W  = 8;
    localparam int ROWS_CFG_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 1'd1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd25;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    // Sweep request from the command logic to the store walker
    typedef struct packed {
        logic clear;
        logic scroll;
    } t_walk_cmd;

endpackage

@@ sv/tcce_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data comes out in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tcce_walk.sv @@
// Store walker: clearing pass over the whole cell store, and the scroll
// (row copy one cell a cycle, then a fill of the bottom row with spaces).
// Depends on tcce_pkg.
module tcce_walk #(
    parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcce_pkg::MAX_ROWS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  tcce_pkg::t_walk_cmd                           i_cmd,
    input  logic [$clog2(MAX_COLUMNS)-1:0]                i_last_col,
    input  logic [$clog2(MAX_ROWS)-1:0]                   i_last_row,
    input  logic [tcce_pkg::CHAR_W-1:0]                   i_rdata,
    output logic                                          o_busy,
    output logic                                          o_we,
    output logic [$clog2(MAX_ROWS*MAX_COLUMNS)-1:0]       o_waddr,
    output logic [tcce_pkg::CHAR_W-1:0]                   o_wdata,
    output logic [$clog2(MAX_ROWS*MAX_COLUMNS)-1:0]       o_raddr
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CLEAR = 2'd1;
    localparam logic [1:0] PH_COPY  = 2'd2;
    localparam logic [1:0] PH_FILL  = 2'd3;

    logic [1:0]        r_phase;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [ADDR_W-1:0] r_base;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_last_col;
    logic [ROW_W-1:0]  r_last_row;

    // Sequence the sweeps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLEAR;
            r_clr_addr <= '0;
            r_wr_pend  <= 1'b0;
        end else begin
            // a copy read issued now is written back next cycle
            r_wr_pend <= (r_phase == PH_COPY);
            unique case (r_phase)
                PH_IDLE: begin
                    r_col      <= '0;
                    r_row      <= '0;
                    r_base     <= '0;
                    r_last_col <= i_last_col;
                    r_last_row <= i_last_row;
                    r_clr_addr <= '0;
                    if (i_cmd.clear) begin
                        r_phase <= PH_CLEAR;
                    end else if (i_cmd.scroll) begin
                        r_phase <= (i_last_row == '0) ? PH_FILL : PH_COPY;
                    end
                end
                PH_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_phase <= PH_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                PH_COPY: begin
                    r_wr_addr <= r_base + ADDR_W'(r_col);
                    if (r_col == r_last_col) begin
                        r_col  <= '0;
                        r_row  <= r_row + 1'b1;
                        r_base <= r_base + ADDR_W'(MAX_COLUMNS);
                        if (r_row + 1'b1 == r_last_row) begin
                            r_phase <= PH_FILL;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                PH_FILL: begin
                    // hold while the last copy write drains
                    if (!r_wr_pend) begin
                        if (r_col == r_last_col) begin
                            r_phase <= PH_IDLE;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // Read one row below the row being written
    assign o_raddr = r_base + ADDR_W'(MAX_COLUMNS) + ADDR_W'(r_col);

    // Drive the write port
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_wr_addr;
        o_wdata = i_rdata;
        priority if (r_phase == PH_CLEAR) begin
            o_we    = 1'b1;
            o_waddr = r_clr_addr;
            o_wdata = '0;
        end else if (r_wr_pend) begin
            o_we    = 1'b1;
            o_waddr = r_wr_addr;
            o_wdata = i_rdata;
        end else if (r_phase == PH_FILL) begin
            o_we    = 1'b1;
            o_waddr = r_base + ADDR_W'(r_col);
            o_wdata = tcce_pkg::CH_SPACE;
        end else begin
            o_we    = 1'b0;
        end
    end

    assign o_busy = (r_phase != PH_IDLE) || r_wr_pend;

endmodule

@@ sv/text_console_cell_engine.sv @@
// Text console cell engine: cursor and command logic over a cell store RAM.
// Depends on tcce_pkg, tcce_ram and tcce_walk.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   a write of a character byte or a read of one cell. Output channel
//   (o_out_valid / i_out_stall) returns one result per command: cursor after
//   the command, the cell read, and scroll / clear flags.
//   A write that neither scrolls nor clears goes through S_DONE to the output
//   register; a read first passes S_READ, which takes the registered RAM read.
//   A new command is taken once the previous one has moved its result to the
//   output register, so no command is taken while the last is still in flight.
//   A scroll is done by the store walker through the single RAM (row copy
//   one cell a cycle, then the bottom row fill). A form feed clears all
//   MAX_ROWS * MAX_COLUMNS cells, one per cycle. Reset runs the same clearing
//   pass with o_in_stall high; configuration writes are taken throughout.
//   A stalled output holds its result; the engine then finishes the next
//   command and waits with it until the output register frees up.
module text_console_cell_engine #(
    parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcce_pkg::MAX_ROWS_DEF,
    parameter int TAB_STOP    = tcce_pkg::TAB_STOP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [tcce_pkg::CHAR_W-1:0]         i_char_code,
    input  logic [tcce_pkg::READ_ROW_W-1:0]     i_read_row,
    input  logic [tcce_pkg::READ_COL_W-1:0]     i_read_col,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tcce_pkg::CURSOR_COL_W-1:0]   o_cursor_col,
    output logic [tcce_pkg::CURSOR_ROW_W-1:0]   o_cursor_row,
    output logic [tcce_pkg::CHAR_W-1:0]         o_cell_value,
    output logic                                o_scrolled,
    output logic                                o_cleared
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CCMP_W = tcce_pkg::COLS_CFG_W + 1;
    localparam int RCMP_W = tcce_pkg::ROWS_CFG_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // configuration and control state
    logic [tcce_pkg::COLS_CFG_W-1:0] r_cfg_cols;
    logic [tcce_pkg::ROWS_CFG_W-1:0] r_cfg_rows;
    logic [1:0]                      r_state;
    logic                            r_has_res;
    logic [COL_W-1:0]                r_col;
    logic [ROW_W-1:0]                r_row;
    logic                            r_out_valid;

    // result staging and output registers
    logic [COL_W-1:0]            r_res_col;
    logic [ROW_W-1:0]            r_res_row;
    logic [tcce_pkg::CHAR_W-1:0] r_res_val;
    logic                        r_res_scr;
    logic                        r_res_clr;
    logic                        r_rd_ok;
    logic [tcce_pkg::CURSOR_COL_W-1:0] r_out_col;
    logic [tcce_pkg::CURSOR_ROW_W-1:0] r_out_row;
    logic [tcce_pkg::CHAR_W-1:0]       r_out_val;
    logic                              r_out_scr;
    logic                              r_out_clr;

    logic [COL_W-1:0]  w_last_col;
    logic [ROW_W-1:0]  w_last_row;
    logic [COL_W-1:0]  w_cur_col;
    logic [ROW_W-1:0]  w_cur_row;
    logic [COL_W:0]    w_tab_next [MAX_COLUMNS];
    logic              w_acc;
    logic              w_out_free;
    logic              w_nl_scroll;
    logic [ROW_W-1:0]  w_nl_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic              n_scroll;
    logic              n_clear;
    logic              w_store;
    logic              w_rd_ok;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;

    tcce_pkg::t_walk_cmd         w_walk_cmd;
    logic                        w_walk_busy;
    logic                        w_walk_we;
    logic [ADDR_W-1:0]           w_walk_waddr;
    logic [tcce_pkg::CHAR_W-1:0] w_walk_wdata;
    logic [ADDR_W-1:0]           w_walk_raddr;

    logic                        w_ram_we;
    logic [ADDR_W-1:0]           w_ram_waddr;
    logic [tcce_pkg::CHAR_W-1:0] w_ram_wdata;
    logic [ADDR_W-1:0]           w_ram_raddr;
    logic [tcce_pkg::CHAR_W-1:0] w_ram_rdata;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= tcce_pkg::COLS_RESET;
            r_cfg_rows <= tcce_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcce_pkg::REG_COLUMNS: r_cfg_cols <= i_cfg_data;
                tcce_pkg::REG_ROWS:    r_cfg_rows <= i_cfg_data[tcce_pkg::ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the register values to the last column and row in use
    always_comb begin
        if (r_cfg_cols == '0) begin
            w_last_col = '0;
        end else if (CCMP_W'(r_cfg_cols) > CCMP_W'(MAX_COLUMNS)) begin
            w_last_col = COL_W'(MAX_COLUMNS - 1);
        end else begin
            w_last_col = COL_W'(r_cfg_cols - 1'b1);
        end
        if (r_cfg_rows == '0) begin
            w_last_row = '0;
        end else if (RCMP_W'(r_cfg_rows) > RCMP_W'(MAX_ROWS)) begin
            w_last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            w_last_row = ROW_W'(r_cfg_rows - 1'b1);
        end
    end

    // Next tab stop for every column
    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_tab
        assign w_tab_next[g] = (COL_W + 1)'((g / TAB_STOP + 1) * TAB_STOP);
    end

    // Cursor clipped to the screen, and the new-line step
    assign w_cur_col   = (r_col > w_last_col) ? w_last_col : r_col;
    assign w_cur_row   = (r_row > w_last_row) ? w_last_row : r_row;
    assign w_nl_scroll = (w_cur_row == w_last_row);
    assign w_nl_row    = w_nl_scroll ? w_cur_row : w_cur_row + 1'b1;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Interpret the command
    always_comb begin
        n_col    = w_cur_col;
        n_row    = w_cur_row;
        n_scroll = 1'b0;
        n_clear  = 1'b0;
        w_store  = 1'b0;
        if (i_command == tcce_pkg::CMD_WRITE) begin
            unique case (i_char_code)
                tcce_pkg::CH_BS, tcce_pkg::CH_DEL: begin
                    if (w_cur_col != '0) begin
                        n_col = w_cur_col - 1'b1;
                    end
                end
                tcce_pkg::CH_HT: begin
                    if (w_tab_next[w_cur_col] > {1'b0, w_last_col}) begin
                        n_col = w_last_col;
                    end else begin
                        n_col = w_tab_next[w_cur_col][COL_W-1:0];
                    end
                end
                tcce_pkg::CH_LF: begin
                    n_col    = '0;
                    n_row    = w_nl_row;
                    n_scroll = w_nl_scroll;
                end
                tcce_pkg::CH_VT: begin
                    n_row    = w_nl_row;
                    n_scroll = w_nl_scroll;
                end
                tcce_pkg::CH_FF: begin
                    n_col   = '0;
                    n_row   = '0;
                    n_clear = 1'b1;
                end
                tcce_pkg::CH_CR: begin
                    n_col = '0;
                end
                default: begin
                    // store at the cursor and advance, wrap after the last column
                    w_store = 1'b1;
                    if (w_cur_col == w_last_col) begin
                        n_col    = '0;
                        n_row    = w_nl_row;
                        n_scroll = w_nl_scroll;
                    end else begin
                        n_col = w_cur_col + 1'b1;
                    end
                end
            endcase
        end
    end

    // Cell addresses
    assign w_rd_ok   = (int'(i_read_row) < MAX_ROWS) && (int'(i_read_col) < MAX_COLUMNS);
    assign w_rd_addr = ADDR_W'(int'(i_read_row) * MAX_COLUMNS + int'(i_read_col));
    assign w_wr_addr = ADDR_W'(int'(w_cur_row) * MAX_COLUMNS + int'(w_cur_col));

    // Start a sweep when a command scrolls or clears
    assign w_walk_cmd.clear  = w_acc && n_clear;
    assign w_walk_cmd.scroll = w_acc && n_scroll;

    // Sequence one command at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WALK;
            r_has_res   <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise valid for a new result, drop it once the receiver takes it
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_col     <= n_col;
                        r_row     <= n_row;
                        r_res_col <= n_col;
                        r_res_row <= n_row;
                        r_res_val <= '0;
                        r_res_scr <= n_scroll;
                        r_res_clr <= n_clear;
                        r_rd_ok   <= w_rd_ok;
                        r_has_res <= 1'b1;
                        priority if (i_command == tcce_pkg::CMD_READ) begin
                            r_state <= S_READ;
                        end else if (n_scroll || n_clear) begin
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    r_res_val <= r_rd_ok ? w_ram_rdata : '0;
                    r_state   <= S_DONE;
                end
                S_WALK: begin
                    if (!w_walk_busy) begin
                        r_state <= r_has_res ? S_DONE : S_IDLE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_col   <= tcce_pkg::CURSOR_COL_W'(r_res_col);
                        r_out_row   <= tcce_pkg::CURSOR_ROW_W'(r_res_row);
                        r_out_val   <= r_res_val;
                        r_out_scr   <= r_res_scr;
                        r_out_clr   <= r_res_clr;
                        r_has_res   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_value = r_out_val;
    assign o_scrolled   = r_out_scr;
    assign o_cleared    = r_out_clr;

    tcce_walk #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_walk_cmd),
        .i_last_col (w_last_col),
        .i_last_row (w_last_row),
        .i_rdata    (w_ram_rdata),
        .o_busy     (w_walk_busy),
        .o_we       (w_walk_we),
        .o_waddr    (w_walk_waddr),
        .o_wdata    (w_walk_wdata),
        .o_raddr    (w_walk_raddr)
    );

    // Hand the RAM to the walker while it sweeps
    assign w_ram_we    = w_walk_busy ? w_walk_we    : (w_acc && w_store);
    assign w_ram_waddr = w_walk_busy ? w_walk_waddr : w_wr_addr;
    assign w_ram_wdata = w_walk_busy ? w_walk_wdata : i_char_code;
    assign w_ram_raddr = w_walk_busy ? w_walk_raddr : w_rd_addr;

    tcce_ram #(
        .WIDTH (tcce_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

@@ tb/text_console_cell_engine_tb.sv @@
// Self-checking testbench for text_console_cell_engine: scripted and random commands
// under random idling, checked against a cycle-free shadow of the console.
// Depends on tcce_pkg and the text_console_cell_engine RTL.
module text_console_cell_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 2;
    // clear pass after reset and form feeds sweeps all MAX_ROWS * MAX_COLUMNS cells
    localparam int IDLE_LIMIT    = 60000;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT  = 10;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 135;
    localparam int NUM_SCRIPTED  = 29;
    localparam int MAX_COLS      = tcce_pkg::MAX_COLUMNS_DEF;
    localparam int MAX_LINES     = tcce_pkg::MAX_ROWS_DEF;
    localparam int STORE_CELLS   = MAX_LINES * MAX_COLS;

    typedef struct packed {
        logic                            cmd;
        logic [tcce_pkg::CHAR_W-1:0]     ch;
        logic [tcce_pkg::READ_ROW_W-1:0] row;
        logic [tcce_pkg::READ_COL_W-1:0] col;
    } t_console_cmd;

    typedef struct packed {
        logic [tcce_pkg::CURSOR_COL_W-1:0] cur_col;
        logic [tcce_pkg::CURSOR_ROW_W-1:0] cur_row;
        logic [tcce_pkg::CHAR_W-1:0]       cell_val;
        logic                              scrolled;
        logic                              cleared;
    } t_console_res;

    typedef enum logic {STEP_ITEM, STEP_REG} t_step_kind;

    typedef struct packed {
        t_step_kind                       kind;
        logic [tcce_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [tcce_pkg::CFG_DATA_W-1:0]  reg_val;
        t_console_cmd                     item;
        logic                             typed;
        t_console_res                     want;
    } t_script_step;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [tcce_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [tcce_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_stall;
    logic                              i_command   = tcce_pkg::CMD_WRITE;
    logic [tcce_pkg::CHAR_W-1:0]       i_char_code = '0;
    logic [tcce_pkg::READ_ROW_W-1:0]   i_read_row  = '0;
    logic [tcce_pkg::READ_COL_W-1:0]   i_read_col  = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [tcce_pkg::CURSOR_COL_W-1:0] o_cursor_col;
    logic [tcce_pkg::CURSOR_ROW_W-1:0] o_cursor_row;
    logic [tcce_pkg::CHAR_W-1:0]       o_cell_value;
    logic                              o_scrolled;
    logic                              o_cleared;

    text_console_cell_engine DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_value (o_cell_value),
        .o_scrolled   (o_scrolled),
        .o_cleared    (o_cleared)
    );

    // Shadow copy of the console: cells, cursor and the two geometry registers
    logic [tcce_pkg::CHAR_W-1:0]     shadow_cells [STORE_CELLS];
    int                              cur_col  = 0;
    int                              cur_row  = 0;
    logic [tcce_pkg::COLS_CFG_W-1:0] cols_reg = tcce_pkg::COLS_RESET;
    logic [tcce_pkg::ROWS_CFG_W-1:0] rows_reg = tcce_pkg::ROWS_RESET;

    t_console_res pending_results [$];
    int           fail_count  = 0;
    int           out_hold    = 0;
    int           idle_cycles = 0;
    bit           quiet_phase = 1'b0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int screen_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic int screen_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_LINES) return MAX_LINES;
        return int'(rows_reg);
    endfunction

    function automatic int draw_wait();
        return quiet_phase ? 0 : $urandom_range(0, 5);
    endfunction

    // Move the cursor down one line; scroll the visible area when on the bottom row
    function automatic logic advance_line(int cols, int rows);
        int r;
        int c;
        cur_row++;
        if (cur_row < rows) return 1'b0;
        cur_row = rows - 1;
        for (r = 0; r + 1 < rows; r++)
            for (c = 0; c < cols; c++)
                shadow_cells[r * MAX_COLS + c] =
                    shadow_cells[(r + 1) * MAX_COLS + c];
        for (c = 0; c < cols; c++)
            shadow_cells[(rows - 1) * MAX_COLS + c] = tcce_pkg::CH_SPACE;
        return 1'b1;
    endfunction

    // Apply one command to the shadow console and return the result it gives
    function automatic t_console_res apply_console_item(t_console_cmd c);
        int           cols;
        int           rows;
        t_console_res res;
        cols = screen_cols();
        rows = screen_rows();
        res  = '0;
        // cursor may sit outside a screen that was just made smaller
        if (cur_col >= cols) cur_col = cols - 1;
        if (cur_row >= rows) cur_row = rows - 1;
        if (c.cmd == tcce_pkg::CMD_READ) begin
            res.cell_val = shadow_cells[int'(c.row) * MAX_COLS + int'(c.col)];
        end else begin
            case (c.ch)
                tcce_pkg::CH_BS, tcce_pkg::CH_DEL: begin
                    if (cur_col > 0) cur_col--;
                end
                tcce_pkg::CH_HT: begin
                    cur_col += tcce_pkg::TAB_STOP_DEF - (cur_col % tcce_pkg::TAB_STOP_DEF);
                    if (cur_col >= cols) cur_col = cols - 1;
                end
                tcce_pkg::CH_LF: begin
                    cur_col      = 0;
                    res.scrolled = advance_line(cols, rows);
                end
                tcce_pkg::CH_VT: begin
                    res.scrolled = advance_line(cols, rows);
                end
                tcce_pkg::CH_FF: begin
                    foreach (shadow_cells[i]) shadow_cells[i] = '0;
                    cur_col     = 0;
                    cur_row     = 0;
                    res.cleared = 1'b1;
                end
                tcce_pkg::CH_CR: begin
                    cur_col = 0;
                end
                default: begin
                    shadow_cells[cur_row * MAX_COLS + cur_col] = c.ch;
                    cur_col++;
                    if (cur_col >= cols) begin
                        res.scrolled = advance_line(cols, rows);
                        cur_col      = 0;
                    end
                end
            endcase
        end
        res.cur_col = tcce_pkg::CURSOR_COL_W'(cur_col);
        res.cur_row = tcce_pkg::CURSOR_ROW_W'(cur_row);
        return res;
    endfunction

    // Offer one command after a random gap; hold it until the transfer happens
    task automatic send_item(input t_console_cmd c, input logic typed,
                             input t_console_res typed_res);
        int           gap;
        t_console_res predicted;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= c.cmd;
        i_char_code <= c.ch;
        i_read_row  <= c.row;
        i_read_col  <= c.col;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = apply_console_item(c);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_console_reg(input logic [tcce_pkg::CFG_INDEX_W-1:0] idx,
                                     input logic [tcce_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == tcce_pkg::REG_COLUMNS) cols_reg = tcce_pkg::COLS_CFG_W'(val);
        else rows_reg = tcce_pkg::ROWS_CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: hold stall for the drawn number of cycles
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_console_res got;
        t_console_res want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got = '{o_cursor_col, o_cursor_row, o_cell_value, o_scrolled, o_cleared};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result col %0d row %0d cell %02h scr %0b clr %0b",
                             $realtime, got.cur_col, got.cur_row, got.cell_val,
                             got.scrolled, got.cleared);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch exp col %0d row %0d cell %02h scr %0b clr %0b,",
                                  " got col %0d row %0d cell %02h scr %0b clr %0b"},
                                 $realtime, want.cur_col, want.cur_row, want.cell_val,
                                 want.scrolled, want.cleared, got.cur_col, got.cur_row,
                                 got.cell_val, got.scrolled, got.cleared);
                end
            end
            out_hold = draw_wait();
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_script_step                    console_script [NUM_SCRIPTED];
        t_console_cmd                    item;
        logic [tcce_pkg::CFG_DATA_W-1:0] new_cols;
        logic [tcce_pkg::CFG_DATA_W-1:0] new_rows;
        int                              pick;
        int                              phase;

        foreach (shadow_cells[i]) shadow_cells[i] = '0;

        // Scripted part: reset contents, every control code, clamps, scrolls on a
        // shrunken screen, out-of-range register values and reads off the screen
        console_script = '{
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd63, 7'd127},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_WRITE, 8'h41, 6'd0, 7'd0},
              1'b1, '{7'd1, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_BS, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_DEL, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_HT, 6'd0, 7'd0},
              1'b1, '{7'd4, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_HT, 6'd0, 7'd0},
              1'b1, '{7'd8, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_WRITE, 8'hFF, 6'd0, 7'd0},
              1'b1, '{7'd9, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_WRITE, 8'h00, 6'd0, 7'd0},
              1'b1, '{7'd10, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_CR, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_LF, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd1, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_VT, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd2, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd0, 7'd8},
              1'b1, '{7'd0, 6'd2, 8'hFF, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_SPACE, 6'd0, 7'd0},
              1'b1, '{7'd1, 6'd2, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_DEL, 6'd0, 7'd0}, 1'b0, '0},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_FF, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b1}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd0, 7'd8},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_VT, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd1, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_HT, 6'd0, 7'd0},
              1'b1, '{7'd4, 6'd1, 8'h00, 1'b0, 1'b0}},
            // shrink to 3 columns and a zero row count: cursor now off screen
            '{STEP_REG, tcce_pkg::REG_COLUMNS, 8'd3, '0, 1'b0, '0},
            '{STEP_REG, tcce_pkg::REG_ROWS, 8'd0, '0, 1'b0, '0},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_WRITE, 8'h42, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b1, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd0, 7'd2},
              1'b1, '{7'd0, 6'd0, tcce_pkg::CH_SPACE, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd0, 7'd3},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_HT, 6'd0, 7'd0},
              1'b1, '{7'd2, 6'd0, 8'h00, 1'b0, 1'b0}},
            '{STEP_ITEM, '0, 8'h00,
              '{tcce_pkg::CMD_WRITE, tcce_pkg::CH_LF, 6'd0, 7'd0},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b1, 1'b0}},
            // register values above the store size saturate
            '{STEP_REG, tcce_pkg::REG_COLUMNS, 8'hFF, '0, 1'b0, '0},
            '{STEP_REG, tcce_pkg::REG_ROWS, 8'hFF, '0, 1'b0, '0},
            '{STEP_ITEM, '0, 8'h00, '{tcce_pkg::CMD_READ, 8'h00, 6'd63, 7'd127},
              1'b1, '{7'd0, 6'd0, 8'h00, 1'b0, 1'b0}}
        };

        // hold reset low, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (console_script[s]) begin
            if (console_script[s].kind == STEP_REG) begin
                drain_results();
                write_console_reg(console_script[s].reg_idx, console_script[s].reg_val);
            end else begin
                send_item(console_script[s].item, console_script[s].typed,
                          console_script[s].want);
            end
        end

        // Random part: one screen geometry per phase, registers written while idle
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin new_cols = 8'd128; new_rows = 8'd64; end
                1: begin new_cols = 8'd0;   new_rows = 8'd0;  end
                2: begin new_cols = 8'd1;   new_rows = 8'd64; end
                3: begin
                    new_cols = tcce_pkg::COLS_RESET;
                    new_rows = tcce_pkg::CFG_DATA_W'(tcce_pkg::ROWS_RESET);
                end
                default: begin
                    new_cols = tcce_pkg::CFG_DATA_W'($urandom_range(1, 20));
                    new_rows = tcce_pkg::CFG_DATA_W'($urandom_range(1, 8));
                end
            endcase
            drain_results();
            write_console_reg(tcce_pkg::REG_COLUMNS, new_cols);
            write_console_reg(tcce_pkg::REG_ROWS, new_rows);
            quiet_phase = ($urandom_range(0, 3) == 0);

            repeat (PHASE_ITEMS) begin
                item.cmd = tcce_pkg::CMD_WRITE;
                item.ch  = tcce_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
                item.row = tcce_pkg::READ_ROW_W'($urandom);
                item.col = tcce_pkg::READ_COL_W'($urandom);
                pick     = $urandom_range(0, 99);
                if (pick < 25) begin
                    item.cmd = tcce_pkg::CMD_READ;
                    // half the reads are drawn inside the visible screen
                    if ($urandom_range(0, 1) == 1) begin
                        item.row = tcce_pkg::READ_ROW_W'($urandom_range(0, screen_rows() - 1));
                        item.col = tcce_pkg::READ_COL_W'($urandom_range(0, screen_cols() - 1));
                    end
                end else if (pick == 25) begin
                    item.ch = tcce_pkg::CH_FF;
                end else if (pick < 45) begin
                    case ($urandom_range(0, 5))
                        0:       item.ch = tcce_pkg::CH_BS;
                        1:       item.ch = tcce_pkg::CH_HT;
                        2:       item.ch = tcce_pkg::CH_LF;
                        3:       item.ch = tcce_pkg::CH_VT;
                        4:       item.ch = tcce_pkg::CH_CR;
                        default: item.ch = tcce_pkg::CH_DEL;
                    endcase
                end else if (pick < 55) begin
                    item.ch = tcce_pkg::CHAR_W'($urandom_range(0, 255));
                end
                // now and then let the engine run completely dry
                if ($urandom_range(0, 79) == 0) drain_results();
                send_item(item, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
